// ===== rtl/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg
// types and constants shared by the peer state table
// ----------------------------------------------------------------------------
package pst_pkg;

    typedef enum logic [3:0] {
        OP_CLEAR     = 4'd0,
        OP_DISCOVERY = 4'd1,
        OP_PAIRING   = 4'd2,
        OP_PAIRED    = 4'd3,
        OP_OFFLINE   = 4'd4,
        OP_REMOVE    = 4'd5,
        OP_PIN       = 4'd6,
        OP_LIVENESS  = 4'd7,
        OP_RETRY     = 4'd8,
        OP_GET       = 4'd9
    } t_op;

    localparam logic [1:0] ST_DISCOVERED = 2'd0;
    localparam logic [1:0] ST_PAIRING    = 2'd1;
    localparam logic [1:0] ST_PAIRED     = 2'd2;
    localparam logic [1:0] ST_OFFLINE    = 2'd3;

    typedef struct packed {
        logic [3:0]  op;
        logic [47:0] mac;
        logic [7:0]  rssi;
        logic [31:0] now_ms;
        logic        pinned_value;
        logic        online_value;
        logic [31:0] retry_wait_ms;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [1:0]  peer_state;
        logic [7:0]  peer_rssi;
        logic [31:0] peer_last_seen;
        logic        peer_online;
        logic        peer_pinned;
        logic [7:0]  peer_retries;
        logic [31:0] peer_backoff_until;
        logic [4:0]  peer_count;
    } t_rsp;

    // stored record of one peer, without the key
    typedef struct packed {
        logic [1:0]  state;
        logic [7:0]  rssi;
        logic [31:0] seen;
        logic        online;
        logic        pinned;
        logic [7:0]  retries;
        logic [31:0] backoff;
    } t_rec;

endpackage

// ===== rtl/pst_if.sv =====
// ----------------------------------------------------------------------------
// pst_req_if / pst_rsp_if
// valid/ready channels for request and result words
// ----------------------------------------------------------------------------
interface pst_req_if;
    logic            valid;
    logic            ready;
    pst_pkg::t_req   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pst_rsp_if;
    logic            valid;
    logic            ready;
    pst_pkg::t_rsp   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pst_front.sv =====
// ----------------------------------------------------------------------------
// pst_front
// accepts request words and queues them in a two-entry fifo
// ----------------------------------------------------------------------------
module pst_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pst_req_if.sink       i_req,
    input  logic          i_pop,
    output logic          o_avail,
    output pst_pkg::t_req o_head
);
    import pst_pkg::*;

    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    wire push = i_req.valid && i_req.ready;
    wire pop  = i_pop && o_avail;

    assign i_req.ready = (r_cnt != 2'd2);
    assign o_avail     = (r_cnt != 2'd0);
    assign o_head      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_req.data;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/pst_back.sv =====
// ----------------------------------------------------------------------------
// pst_back
// scans the table one entry a cycle, then applies the operation
// ----------------------------------------------------------------------------
module pst_back #(
    parameter int PEER_CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_avail,
    input  pst_pkg::t_req i_head,
    output logic          o_pop,
    pst_rsp_if.source     o_rsp
);
    import pst_pkg::*;

    localparam int IW = (PEER_CAPACITY > 1) ? $clog2(PEER_CAPACITY) : 1;
    localparam int CW = $clog2(PEER_CAPACITY + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_APPLY, S_OUT} t_state;

    t_state              r_st;
    logic [47:0]         r_mac [PEER_CAPACITY];
    t_rec                r_rec [PEER_CAPACITY];
    logic [PEER_CAPACITY-1:0] r_valid;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_idx;
    logic                r_hit, r_free;
    logic [IW-1:0]       r_hit_i, r_free_i;
    t_rec                r_cur;
    t_req                r_req;
    t_rsp                r_out;

    wire [IW-1:0] idx = r_idx[IW-1:0];
    wire [IW-1:0] sel = r_hit ? r_hit_i : r_free_i;

    assign o_rsp.valid = (r_st == S_OUT);
    assign o_rsp.data  = r_out;
    assign o_pop       = (r_st == S_IDLE) && i_avail;

    always_ff @(posedge i_clk) begin
        t_rec nr;
        t_rsp rs;
        logic wr;
        nr = r_cur;
        rs = '0;
        wr = 1'b0;
        if (r_st == S_READ) r_cur <= r_rec[sel];
        if (r_st == S_APPLY) begin
            if (!r_hit) begin
                nr = '0;
                nr.seen = r_req.now_ms;
            end
            unique case (r_req.op)
                OP_DISCOVERY: begin
                    nr.rssi = r_req.rssi;
                    nr.seen = r_req.now_ms;
                    if (!r_hit) nr.state = ST_DISCOVERED;
                    else if (nr.state == ST_OFFLINE) nr.state = ST_DISCOVERED;
                end
                OP_PAIRING: begin
                    nr.state = ST_PAIRING;
                    nr.seen  = r_req.now_ms;
                end
                OP_PAIRED: begin
                    nr.state = ST_PAIRED;
                    nr.seen = r_req.now_ms;
                    nr.online = 1'b1;
                    nr.retries = '0;
                    nr.backoff = '0;
                end
                OP_OFFLINE: begin
                    nr.state = ST_OFFLINE;
                    nr.online = 1'b0;
                    nr.seen = r_req.now_ms;
                end
                OP_PIN: nr.pinned = r_req.pinned_value;
                OP_LIVENESS: begin
                    nr.online = r_req.online_value;
                    nr.seen = r_req.now_ms;
                    nr.state = r_req.online_value ? ST_PAIRED : ST_OFFLINE;
                end
                OP_RETRY: begin
                    if (nr.retries != 8'hFF) nr.retries = nr.retries + 8'd1;
                    nr.seen = r_req.now_ms;
                    nr.backoff = r_req.now_ms + r_req.retry_wait_ms;
                end
                default: ;
            endcase
            wr = (r_req.op == OP_DISCOVERY || r_req.op == OP_PAIRING ||
                  r_req.op == OP_PAIRED) ? (r_hit || r_free) :
                 (r_req.op == OP_OFFLINE || r_req.op == OP_PIN ||
                  r_req.op == OP_LIVENESS || r_req.op == OP_RETRY) && r_hit;
            if (wr) begin
                r_rec[sel] <= nr;
                r_mac[sel] <= r_req.mac;
            end
            if (wr || (r_hit && (r_req.op == OP_REMOVE || r_req.op == OP_GET))) begin
                rs.ok = 1'b1;
                rs.peer_state = nr.state;
                rs.peer_rssi = nr.rssi;
                rs.peer_last_seen = nr.seen;
                rs.peer_online = nr.online;
                rs.peer_pinned = nr.pinned;
                rs.peer_retries = nr.retries;
                rs.peer_backoff_until = nr.backoff;
            end
            if (r_req.op == OP_CLEAR) rs.ok = 1'b1;
            // count after the operation
            if (r_req.op == OP_CLEAR) rs.peer_count = '0;
            else if (r_req.op == OP_REMOVE && r_hit) rs.peer_count = 5'(r_count - 1'b1);
            else if (wr && !r_hit) rs.peer_count = 5'(r_count + 1'b1);
            else rs.peer_count = 5'(r_count);
            r_out <= rs;
        end
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: if (i_avail) begin
                    r_req <= i_head;
                    r_idx <= '0;
                    r_hit <= 1'b0;
                    r_free <= 1'b0;
                    r_st <= S_SCAN;
                end
                S_SCAN: begin
                    // first matching entry and lowest free slot
                    if (r_valid[idx] && r_mac[idx] == r_req.mac && !r_hit) begin
                        r_hit <= 1'b1;
                        r_hit_i <= idx;
                    end
                    if (!r_valid[idx] && !r_free) begin
                        r_free <= 1'b1;
                        r_free_i <= idx;
                    end
                    if (r_idx == CW'(PEER_CAPACITY - 1)) r_st <= S_READ;
                    r_idx <= r_idx + 1'b1;
                end
                S_READ: r_st <= S_APPLY;
                S_APPLY: begin
                    if (r_req.op == OP_CLEAR) begin
                        r_valid <= '0;
                        r_count <= '0;
                    end else if (r_req.op == OP_REMOVE && r_hit) begin
                        r_valid[r_hit_i] <= 1'b0;
                        r_count <= r_count - 1'b1;
                    end else if (wr && !r_hit) begin
                        r_valid[r_free_i] <= 1'b1;
                        r_count <= r_count + 1'b1;
                    end
                    r_st <= S_OUT;
                end
                S_OUT: if (o_rsp.ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/peer_state_table.sv =====
// ----------------------------------------------------------------------------
// peer_state_table
// table of wireless peers keyed by MAC address
// ----------------------------------------------------------------------------
//  channel   dir  word
//  i_req     in   op, mac, rssi, now_ms, pinned_value, online_value, retry_wait_ms
//  o_rsp     out  ok, record fields, peer_count
//
//  each item passes through a scan of the entries one a cycle, a record read,
//  the update and the result word; the next item starts once the result is taken
//  a two-word queue takes requests while the back end works or stalls
//  synchronous active-low reset empties the table at once
module peer_state_table #(
    parameter int PEER_CAPACITY = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pst_req_if.sink   i_req,
    pst_rsp_if.source o_rsp
);
    import pst_pkg::*;

    logic avail, pop;
    t_req head;

    pst_front u_front (
        .i_clk, .i_rst_n, .i_req,
        .i_pop(pop), .o_avail(avail), .o_head(head)
    );

    pst_back #(.PEER_CAPACITY(PEER_CAPACITY)) u_back (
        .i_clk, .i_rst_n, .i_avail(avail), .i_head(head),
        .o_pop(pop), .o_rsp
    );
endmodule

// ===== rtl/pst_checker.sv =====
// ----------------------------------------------------------------------------
// pst_checker
// port-level checks on the peer state table
// ----------------------------------------------------------------------------
module pst_checker #(
    parameter int PEER_CAPACITY = 16
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input pst_pkg::t_rsp rsp_data
);
    import pst_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result dropped under stall");
    // the count field wraps only for tables wider than it can show
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> (PEER_CAPACITY > 31) ||
        (rsp_data.peer_count <= 5'(PEER_CAPACITY)))
        else $error("count out of range");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_data.ok |-> rsp_data.peer_last_seen == '0 &&
        rsp_data.peer_retries == '0 && rsp_data.peer_backoff_until == '0)
        else $error("failed result carries a record");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_ready |=> !rsp_valid)
        else $error("results too close");
endmodule

bind peer_state_table pst_checker #(.PEER_CAPACITY(PEER_CAPACITY)) u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready), .rsp_data(o_rsp.data)
);

// ===== test/peer_state_table_chk.sv =====
// ----------------------------------------------------------------------------
// peer_state_table_chk
// watches the request and result channels, predicts each result word from
// its own model of the peer table and compares it field by field
// ----------------------------------------------------------------------------
module peer_state_table_chk #(
    parameter int PEER_CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_ready,
    input  pst_pkg::t_req i_req_data,
    input  logic          i_rsp_valid,
    input  logic          i_rsp_ready,
    input  pst_pkg::t_rsp i_rsp_data,
    output int            o_fail_count,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pst_pkg::*;

    logic        tbl_valid [PEER_CAPACITY];
    logic [47:0] tbl_mac   [PEER_CAPACITY];
    t_rec        tbl_rec   [PEER_CAPACITY];
    int          tbl_count;
    t_rsp        rsp_due_q [$];

    function automatic int find_peer(logic [47:0] mac);
        for (int k = 0; k < PEER_CAPACITY; k++)
            if (tbl_valid[k] && tbl_mac[k] == mac) return k;
        return -1;
    endfunction

    function automatic int add_peer(logic [47:0] mac, logic [31:0] now);
        for (int k = 0; k < PEER_CAPACITY; k++)
            if (!tbl_valid[k]) begin
                tbl_valid[k] = 1'b1;
                tbl_mac[k]   = mac;
                tbl_rec[k]   = '0;
                tbl_rec[k].seen = now;
                tbl_count++;
                return k;
            end
        return -1;
    endfunction

    function automatic t_rsp show_peer(int k);
        t_rsp r;
        r = '0;
        r.ok                 = 1'b1;
        r.peer_state         = tbl_rec[k].state;
        r.peer_rssi          = tbl_rec[k].rssi;
        r.peer_last_seen     = tbl_rec[k].seen;
        r.peer_online        = tbl_rec[k].online;
        r.peer_pinned        = tbl_rec[k].pinned;
        r.peer_retries       = tbl_rec[k].retries;
        r.peer_backoff_until = tbl_rec[k].backoff;
        return r;
    endfunction

    function automatic t_rsp apply_request(t_req q);
        t_rsp r;
        int   k;
        r = '0;
        k = (q.op == OP_CLEAR) ? -1 : find_peer(q.mac);
        case (q.op)
            OP_CLEAR: begin
                for (int j = 0; j < PEER_CAPACITY; j++) tbl_valid[j] = 1'b0;
                tbl_count = 0;
                r.ok = 1'b1;
            end
            OP_DISCOVERY: begin
                if (k < 0) begin
                    k = add_peer(q.mac, q.now_ms);
                    if (k >= 0) tbl_rec[k].rssi = q.rssi;
                end else begin
                    tbl_rec[k].rssi = q.rssi;
                    tbl_rec[k].seen = q.now_ms;
                    if (tbl_rec[k].state == ST_OFFLINE) tbl_rec[k].state = ST_DISCOVERED;
                end
            end
            OP_PAIRING: begin
                if (k < 0) k = add_peer(q.mac, q.now_ms);
                if (k >= 0) begin
                    tbl_rec[k].state = ST_PAIRING;
                    tbl_rec[k].seen  = q.now_ms;
                end
            end
            OP_PAIRED: begin
                if (k < 0) k = add_peer(q.mac, q.now_ms);
                if (k >= 0) begin
                    tbl_rec[k].state   = ST_PAIRED;
                    tbl_rec[k].seen    = q.now_ms;
                    tbl_rec[k].online  = 1'b1;
                    tbl_rec[k].retries = '0;
                    tbl_rec[k].backoff = '0;
                end
            end
            OP_OFFLINE: if (k >= 0) begin
                tbl_rec[k].state  = ST_OFFLINE;
                tbl_rec[k].online = 1'b0;
                tbl_rec[k].seen   = q.now_ms;
            end
            OP_REMOVE: if (k >= 0) begin
                r = show_peer(k);
                tbl_valid[k] = 1'b0;
                tbl_count--;
                k = -1;
            end
            OP_PIN: if (k >= 0) tbl_rec[k].pinned = q.pinned_value;
            OP_LIVENESS: if (k >= 0) begin
                tbl_rec[k].online = q.online_value;
                tbl_rec[k].seen   = q.now_ms;
                tbl_rec[k].state  = q.online_value ? ST_PAIRED : ST_OFFLINE;
            end
            OP_RETRY: if (k >= 0) begin
                if (tbl_rec[k].retries != 8'hff) tbl_rec[k].retries++;
                tbl_rec[k].seen    = q.now_ms;
                tbl_rec[k].backoff = q.now_ms + q.retry_wait_ms;
            end
            OP_GET: ;
            default: k = -1;
        endcase
        if (k >= 0) r = show_peer(k);
        r.peer_count = tbl_count[4:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp due;
        if (!i_rst_n) begin
            for (int j = 0; j < PEER_CAPACITY; j++) tbl_valid[j] = 1'b0;
            tbl_count = 0;
            rsp_due_q.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                due = apply_request(i_req_data);
                rsp_due_q = {rsp_due_q, due};
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_due_q.size() == 0) begin
                    $error("result word with nothing expected");
                    o_fail_count++;
                end else begin
                    want = rsp_due_q.pop_front();
                    check_field("ok", 48'(want.ok), 48'(i_rsp_data.ok));
                    check_field("peer_state", 48'(want.peer_state),
                                48'(i_rsp_data.peer_state));
                    check_field("peer_rssi", 48'(want.peer_rssi),
                                48'(i_rsp_data.peer_rssi));
                    check_field("peer_last_seen", 48'(want.peer_last_seen),
                                48'(i_rsp_data.peer_last_seen));
                    check_field("peer_online", 48'(want.peer_online),
                                48'(i_rsp_data.peer_online));
                    check_field("peer_pinned", 48'(want.peer_pinned),
                                48'(i_rsp_data.peer_pinned));
                    check_field("peer_retries", 48'(want.peer_retries),
                                48'(i_rsp_data.peer_retries));
                    check_field("peer_backoff_until", 48'(want.peer_backoff_until),
                                48'(i_rsp_data.peer_backoff_until));
                    check_field("peer_count", 48'(want.peer_count),
                                48'(i_rsp_data.peer_count));
                end
            end
        end
        o_pending = rsp_due_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

// ===== test/peer_state_table_tb.sv =====
// ----------------------------------------------------------------------------
// peer_state_table_tb
// directed and random peer operations over a small pool of MAC addresses so
// that lookups hit, the table fills and empties; idling on both sides and a
// long result hold-off that backs the block up
// ----------------------------------------------------------------------------
module peer_state_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pst_pkg::*;

    localparam int CAP = 16;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   src_idle_pct;
    int   snk_idle_pct;
    bit   hold_off;
    bit   stim_done;
    logic [47:0] mac_pool [24];

    pst_req_if req_if ();
    pst_rsp_if rsp_if ();

    peer_state_table #(.PEER_CAPACITY(CAP)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    peer_state_table_chk #(.PEER_CAPACITY(CAP)) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_if.valid),
        .i_req_ready  (req_if.ready),
        .i_req_data   (req_if.data),
        .i_rsp_valid  (rsp_if.valid),
        .i_rsp_ready  (rsp_if.ready),
        .i_rsp_data   (rsp_if.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    function automatic t_req rand_word(t_op op, logic [47:0] mac);
        t_req q;
        q.op            = op;
        q.mac           = mac;
        q.rssi          = 8'($urandom);
        q.now_ms        = $urandom;
        q.pinned_value  = 1'($urandom);
        q.online_value  = 1'($urandom);
        q.retry_wait_ms = $urandom;
        return q;
    endfunction

    // valid stays up between words; it drops only for idle cycles
    task automatic send_word(t_req q);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= q;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // result side: random stalls, and a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) rsp_if.ready <= 1'b0;
        else rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    initial begin
        int hold_cnt;
        hold_cnt = 0;
        wait (stim_done == 1'b0 && i_rst_n === 1'b1);
        repeat (300) @(posedge i_clk);
        hold_off = 1'b1;
        while (hold_cnt < 400) begin
            @(posedge i_clk);
            hold_cnt++;
        end
        hold_off = 1'b0;
    end

    initial begin
        t_req q;
        t_op  op;
        int   r;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        hold_off     = 1'b0;
        stim_done    = 1'b0;
        src_idle_pct = 7;
        snk_idle_pct = 71;
        i_rst_n      = 1'b0;
        mac_pool[0]  = '0;
        mac_pool[1]  = '1;
        for (int k = 2; k < 24; k++) mac_pool[k] = {$urandom, 16'($urandom)};
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, every op, misses, full table, clear
        q = rand_word(OP_GET, mac_pool[0]);          send_word(q);
        q = rand_word(OP_RETRY, mac_pool[1]);        send_word(q);
        q = rand_word(OP_DISCOVERY, mac_pool[0]);
        q.rssi = 8'h80; q.now_ms = '1;               send_word(q);
        q = rand_word(OP_DISCOVERY, mac_pool[1]);
        q.rssi = 8'h7f; q.now_ms = '0;               send_word(q);
        q = rand_word(OP_RETRY, mac_pool[1]);
        q.now_ms = '1; q.retry_wait_ms = '1;         send_word(q);
        // retries run into saturation
        for (int k = 0; k < 260; k++) begin
            q = rand_word(OP_RETRY, mac_pool[1]);    send_word(q);
        end
        q = rand_word(OP_OFFLINE, mac_pool[0]);      send_word(q);
        q = rand_word(OP_DISCOVERY, mac_pool[0]);    send_word(q);
        q = rand_word(OP_PIN, mac_pool[0]);
        q.pinned_value = 1'b1;                       send_word(q);
        q = rand_word(OP_LIVENESS, mac_pool[1]);
        q.online_value = 1'b1;                       send_word(q);
        q = rand_word(OP_LIVENESS, mac_pool[1]);
        q.online_value = 1'b0;                       send_word(q);
        q = rand_word(OP_PAIRING, mac_pool[2]);      send_word(q);
        q = rand_word(OP_PAIRED, mac_pool[3]);       send_word(q);
        q = rand_word(OP_REMOVE, mac_pool[0]);       send_word(q);
        q = rand_word(OP_REMOVE, mac_pool[0]);       send_word(q);
        for (int k = 4; k < 22; k++) begin
            q = rand_word(OP_PAIRED, mac_pool[k]);   send_word(q);
        end
        q = rand_word(t_op'(4'd12), mac_pool[1]);    send_word(q);
        q = rand_word(t_op'(4'd15), mac_pool[1]);    send_word(q);
        q = rand_word(OP_CLEAR, mac_pool[1]);        send_word(q);

        for (int n = 0; n < 1700; n++) begin
            if (n == 600) begin
                src_idle_pct = 71; snk_idle_pct = 7;
            end else if (n == 1150) begin
                src_idle_pct = 0; snk_idle_pct = 0;
            end
            r = $urandom_range(99);
            if (r < 1)       op = OP_CLEAR;
            else if (r < 3)  op = t_op'(4'($urandom_range(15, 10)));
            else if (r < 25) op = OP_DISCOVERY;
            else             op = t_op'(4'($urandom_range(9, 2)));
            // mostly pooled keys so most lookups hit, sometimes a fresh one
            if ($urandom_range(9) == 0)
                q = rand_word(op, {$urandom, 16'($urandom)});
            else
                q = rand_word(op, mac_pool[$urandom_range(23)]);
            send_word(q);
        end
        req_if.valid <= 1'b0;
        stim_done = 1'b1;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("peer_state_table regression: pass");
        else
            $display("peer_state_table regression: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("peer_state_table regression: fail");
        $finish;
    end

endmodule
